### rtl/cple_pkg.sv
`timescale 1ns / 1ps

package cple_pkg;

    localparam int unsigned HEAP_DEPTH = 1024;
    localparam int unsigned AW = $clog2(HEAP_DEPTH);
    localparam int unsigned SW = $clog2(HEAP_DEPTH + 1);
    localparam int unsigned CW = AW + 2;

    localparam logic [2:0] FN_ADD_XA = 3'd0;
    localparam logic [2:0] FN_ADD_AX = 3'd1;
    localparam logic [2:0] FN_SHIFT  = 3'd2;
    localparam logic [2:0] FN_CMIN   = 3'd3;
    localparam logic [2:0] FN_EVAL   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REVERSED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [1:0] PS_DST_POS = 2'd0;
    localparam logic [1:0] PS_SRC_POS = 2'd1;
    localparam logic [1:0] PS_SRC_A   = 2'd2;
    localparam logic [1:0] PS_DST_A   = 2'd3;

    typedef logic [4:0] t_op;

    localparam t_op OP_NOP       = 5'd0;
    localparam t_op OP_LOAD      = 5'd1;
    localparam t_op OP_SHIFT     = 5'd2;
    localparam t_op OP_CMIN      = 5'd3;
    localparam t_op OP_RD_TOP    = 5'd4;
    localparam t_op OP_POP_INIT  = 5'd5;
    localparam t_op OP_POP_LAST  = 5'd6;
    localparam t_op OP_RD_L      = 5'd7;
    localparam t_op OP_CMP_L     = 5'd8;
    localparam t_op OP_CMP_R     = 5'd9;
    localparam t_op OP_WR_B      = 5'd10;
    localparam t_op OP_WR_E      = 5'd11;
    localparam t_op OP_TAKE      = 5'd12;
    localparam t_op OP_PUSH_LD   = 5'd13;
    localparam t_op OP_SET_FULL  = 5'd14;
    localparam t_op OP_PUSH_GROW = 5'd15;
    localparam t_op OP_RD_P      = 5'd16;
    localparam t_op OP_WR_UP     = 5'd17;
    localparam t_op OP_DIST      = 5'd18;
    localparam t_op OP_MUL_LO    = 5'd19;
    localparam t_op OP_MIN_HI    = 5'd20;
    localparam t_op OP_MIN_END   = 5'd21;
    localparam t_op OP_EV_INIT   = 5'd22;
    localparam t_op OP_EV_NEXT   = 5'd23;
    localparam t_op OP_EV_RD     = 5'd24;
    localparam t_op OP_EV_DIFF   = 5'd25;
    localparam t_op OP_EV_HI     = 5'd26;
    localparam t_op OP_EV_END    = 5'd27;

    typedef struct packed {
        t_op        op;
        logic [1:0] psel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       loop_go;
        logic       brk;
        logic       pop_single;
        logic       l_in;
        logic       moved;
        logic       p_zero;
        logic       p_full;
        logic       i_zero;
        logic       up;
        logic       ev_more;
        logic       ev_right;
    } t_stat;

    function automatic logic above(input logic is_max,
                                   input logic [63:0] kx, input logic [31:0] wx,
                                   input logic [63:0] ky, input logic [31:0] wy);
        logic keq;
        keq = (kx == ky);
        if (is_max) begin
            return ($signed(ky) < $signed(kx)) || (keq && (wx > wy));
        end
        return ($signed(kx) < $signed(ky)) || (keq && (wx < wy));
    endfunction

endpackage

### rtl/cple_ctrl.sv
`timescale 1ns / 1ps

module cple_ctrl import cple_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output logic  o_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_ADD_CHK  = 5'd2;
    localparam logic [4:0] S_ADD_TOP  = 5'd3;
    localparam logic [4:0] S_POP_LAST = 5'd4;
    localparam logic [4:0] S_SD_L     = 5'd5;
    localparam logic [4:0] S_SD_LW    = 5'd6;
    localparam logic [4:0] S_SD_RW    = 5'd7;
    localparam logic [4:0] S_SD_DEC   = 5'd8;
    localparam logic [4:0] S_TAKE     = 5'd9;
    localparam logic [4:0] S_PUSH_LD  = 5'd10;
    localparam logic [4:0] S_PUSH_ST  = 5'd11;
    localparam logic [4:0] S_SU       = 5'd12;
    localparam logic [4:0] S_SU_W     = 5'd13;
    localparam logic [4:0] S_DIST     = 5'd14;
    localparam logic [4:0] S_MLO      = 5'd15;
    localparam logic [4:0] S_MHI      = 5'd16;
    localparam logic [4:0] S_MEND     = 5'd17;
    localparam logic [4:0] S_EV_CHK   = 5'd18;
    localparam logic [4:0] S_EV_DIFF  = 5'd19;
    localparam logic [4:0] S_EV_MLO   = 5'd20;
    localparam logic [4:0] S_EV_MHI   = 5'd21;
    localparam logic [4:0] S_EV_END   = 5'd22;
    localparam logic [4:0] S_DONE     = 5'd23;

    logic [4:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [4:0] ret_state;
    logic [1:0] ret_phase;

    always_comb begin
        ret_phase = r_phase;
        unique case (r_phase)
            PS_DST_POS: begin ret_state = S_PUSH_LD; ret_phase = PS_SRC_POS; end
            PS_SRC_POS: begin ret_state = S_PUSH_LD; ret_phase = PS_SRC_A; end
            PS_SRC_A:   ret_state = S_DIST;
            default:    ret_state = S_DONE;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        o_cmd.op  = OP_NOP;
        o_cmd.psel = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_stat.func)
                    FN_ADD_XA, FN_ADD_AX: n_state = S_ADD_CHK;
                    FN_SHIFT: begin o_cmd.op = OP_SHIFT; n_state = S_DONE; end
                    FN_CMIN:  begin o_cmd.op = OP_CMIN;  n_state = S_DONE; end
                    FN_EVAL:  begin o_cmd.op = OP_EV_INIT; n_state = S_EV_CHK; end
                    default:  n_state = S_DONE;
                endcase
            end
            S_ADD_CHK: begin
                if (i_stat.loop_go) begin
                    o_cmd.op = OP_RD_TOP;
                    n_state  = S_ADD_TOP;
                end else begin
                    n_phase = PS_DST_A;
                    n_state = S_PUSH_LD;
                end
            end
            S_ADD_TOP: begin
                if (i_stat.brk) begin
                    n_phase = PS_DST_A;
                    n_state = S_PUSH_LD;
                end else begin
                    o_cmd.op = OP_POP_INIT;
                    n_state  = i_stat.pop_single ? S_TAKE : S_POP_LAST;
                end
            end
            S_POP_LAST: begin o_cmd.op = OP_POP_LAST; n_state = S_SD_L; end
            S_SD_L: begin
                if (i_stat.l_in) begin
                    o_cmd.op = OP_RD_L;
                    n_state  = S_SD_LW;
                end else begin
                    o_cmd.op = OP_WR_E;
                    n_state  = S_TAKE;
                end
            end
            S_SD_LW: begin o_cmd.op = OP_CMP_L; n_state = S_SD_RW; end
            S_SD_RW: begin o_cmd.op = OP_CMP_R; n_state = S_SD_DEC; end
            S_SD_DEC: begin
                if (i_stat.moved) begin
                    o_cmd.op = OP_WR_B;
                    n_state  = S_SD_L;
                end else begin
                    o_cmd.op = OP_WR_E;
                    n_state  = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.op = OP_TAKE;
                n_phase  = PS_DST_POS;
                n_state  = S_PUSH_LD;
            end
            S_PUSH_LD: begin o_cmd.op = OP_PUSH_LD; n_state = S_PUSH_ST; end
            S_PUSH_ST: begin
                if (i_stat.p_zero) begin
                    n_state = ret_state;
                    n_phase = ret_phase;
                end else if (i_stat.p_full) begin
                    o_cmd.op = OP_SET_FULL;
                    n_state  = ret_state;
                    n_phase  = ret_phase;
                end else begin
                    o_cmd.op = OP_PUSH_GROW;
                    n_state  = S_SU;
                end
            end
            S_SU: begin
                if (i_stat.i_zero) begin
                    o_cmd.op = OP_WR_E;
                    n_state  = ret_state;
                    n_phase  = ret_phase;
                end else begin
                    o_cmd.op = OP_RD_P;
                    n_state  = S_SU_W;
                end
            end
            S_SU_W: begin
                if (i_stat.up) begin
                    o_cmd.op = OP_WR_UP;
                    n_state  = S_SU;
                end else begin
                    o_cmd.op = OP_WR_E;
                    n_state  = ret_state;
                    n_phase  = ret_phase;
                end
            end
            S_DIST: begin o_cmd.op = OP_DIST;    n_state = S_MLO; end
            S_MLO:  begin o_cmd.op = OP_MUL_LO;  n_state = S_MHI; end
            S_MHI:  begin o_cmd.op = OP_MIN_HI;  n_state = S_MEND; end
            S_MEND: begin o_cmd.op = OP_MIN_END; n_state = S_ADD_CHK; end
            S_EV_CHK: begin
                if (i_stat.ev_more) begin
                    o_cmd.op = OP_EV_RD;
                    n_state  = S_EV_DIFF;
                end else if (!i_stat.ev_right) begin
                    o_cmd.op = OP_EV_NEXT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EV_DIFF: begin o_cmd.op = OP_EV_DIFF; n_state = S_EV_MLO; end
            S_EV_MLO:  begin o_cmd.op = OP_MUL_LO;  n_state = S_EV_MHI; end
            S_EV_MHI:  begin o_cmd.op = OP_EV_HI;   n_state = S_EV_END; end
            S_EV_END:  begin o_cmd.op = OP_EV_END;  n_state = S_EV_CHK; end
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PS_DST_POS;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

### rtl/cple_dp.sv
`timescale 1ns / 1ps

module cple_dp import cple_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_pos_a,
    input  logic [31:0] i_pos_b,
    input  logic [31:0] i_slope_count,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [63:0] o_min_value,
    output logic [63:0] o_eval_value,
    output logic [1:0]  o_status
);

    logic [63:0] r_lkeys [HEAP_DEPTH];
    logic [31:0] r_lwts  [HEAP_DEPTH];
    logic [63:0] r_rkeys [HEAP_DEPTH];
    logic [31:0] r_rwts  [HEAP_DEPTH];
    logic [63:0] r_lq_k, r_rq_k;
    logic [31:0] r_lq_w, r_rq_w;

    logic [SW-1:0] r_lsize, r_rsize, r_n;
    logic [63:0]   r_loff, r_roff, r_min, r_acc;
    logic [2:0]    r_func;
    logic [63:0]   r_a, r_b, r_pos, r_dist, r_prod, r_ek, r_bk;
    logic [31:0]   r_cnt, r_used, r_num, r_take, r_ew, r_bw;
    logic          r_src, r_h, r_full, r_rev, r_iseval, r_moved, r_hit;
    logic [AW-1:0] r_i, r_bidx;
    logic [SW-1:0] r_eidx;

    logic [63:0]   q_k, off_h, off_s, off_d, top, pkey, ev_pos, mul_p;
    logic [31:0]   q_w, rem, pwt, mul_a;
    logic [SW-1:0] size_h, size_s, sz_m1;
    logic [CW-1:0] l_idx, r_idx, n_ext;
    logic [AW-1:0] par, rd_addr, wr_addr;
    logic [63:0]   wr_k;
    logic [31:0]   wr_w;
    logic          wr_en, is_max, r_in, rev_now, ph;

    assign q_k     = r_h ? r_rq_k : r_lq_k;
    assign q_w     = r_h ? r_rq_w : r_lq_w;
    assign off_h   = r_h ? r_roff : r_loff;
    assign size_h  = r_h ? r_rsize : r_lsize;
    assign off_s   = r_src ? r_roff : r_loff;
    assign off_d   = r_src ? r_loff : r_roff;
    assign size_s  = r_src ? r_rsize : r_lsize;
    assign sz_m1   = size_h - SW'(1);
    assign is_max  = !r_h;
    assign top     = q_k + off_h;
    assign ev_pos  = q_k + off_h;
    assign l_idx   = (CW'(r_i) << 1) + CW'(1);
    assign r_idx   = l_idx + CW'(1);
    assign n_ext   = CW'(r_n);
    assign r_in    = (r_idx < n_ext);
    assign par     = (r_i - AW'(1)) >> 1;
    assign rem     = r_cnt - r_used;
    assign rev_now = ($signed(r_b) < $signed(r_a));
    assign mul_a   = ((i_cmd.op == OP_MIN_HI) || (i_cmd.op == OP_EV_HI)) ?
                     r_dist[63:32] : r_dist[31:0];
    assign mul_p   = mul_a * r_take;

    always_comb begin
        unique case (i_cmd.psel)
            PS_DST_POS: begin ph = !r_src; pkey = r_pos - off_d; pwt = r_take; end
            PS_SRC_POS: begin ph = r_src;  pkey = r_pos - off_s; pwt = r_num - r_take; end
            PS_SRC_A:   begin ph = r_src;  pkey = r_a - off_s;   pwt = r_take; end
            default:    begin ph = !r_src; pkey = r_a - off_d;   pwt = rem; end
        endcase
    end

    always_comb begin
        unique case (i_cmd.op)
            OP_POP_INIT: rd_addr = sz_m1[AW-1:0];
            OP_RD_L:     rd_addr = l_idx[AW-1:0];
            OP_CMP_L:    rd_addr = r_idx[AW-1:0];
            OP_RD_P:     rd_addr = par;
            OP_EV_RD:    rd_addr = r_eidx[AW-1:0];
            default:     rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_i;
        unique case (i_cmd.op)
            OP_WR_E:  begin wr_k = r_ek; wr_w = r_ew; end
            OP_WR_UP: begin wr_k = q_k;  wr_w = q_w;  end
            OP_WR_B:  begin wr_k = r_bk; wr_w = r_bw; end
            default:  begin wr_k = r_ek; wr_w = r_ew; wr_en = 1'b0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_h) begin
            r_lkeys[wr_addr] <= wr_k;
            r_lwts[wr_addr]  <= wr_w;
        end
        if (wr_en && r_h) begin
            r_rkeys[wr_addr] <= wr_k;
            r_rwts[wr_addr]  <= wr_w;
        end
        r_lq_k <= r_lkeys[rd_addr];
        r_lq_w <= r_lwts[rd_addr];
        r_rq_k <= r_rkeys[rd_addr];
        r_rq_w <= r_rwts[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lsize <= '0;
            r_rsize <= '0;
            r_loff  <= '0;
            r_roff  <= '0;
            r_min   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_SHIFT: begin
                    if (!rev_now) begin
                        r_loff <= r_loff + r_a;
                        r_roff <= r_roff + r_b;
                    end
                end
                OP_CMIN: r_rsize <= '0;
                OP_POP_INIT: begin
                    if (r_h) r_rsize <= sz_m1;
                    else     r_lsize <= sz_m1;
                end
                OP_PUSH_GROW: begin
                    if (r_h) r_rsize <= size_h + SW'(1);
                    else     r_lsize <= size_h + SW'(1);
                end
                OP_MIN_HI, OP_MIN_END: r_min <= r_min + r_prod;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_func   <= i_func;
                r_a      <= {{32{i_pos_a[31]}}, i_pos_a};
                r_b      <= {{32{i_pos_b[31]}}, i_pos_b};
                r_cnt    <= i_slope_count;
                r_used   <= '0;
                r_full   <= 1'b0;
                r_rev    <= 1'b0;
                r_iseval <= 1'b0;
                r_src    <= (i_func == FN_ADD_AX);
            end
            OP_SHIFT:  r_rev <= rev_now;
            OP_RD_TOP: r_h <= r_src;
            OP_POP_INIT: begin
                r_pos <= top;
                r_num <= q_w;
                r_n   <= sz_m1;
            end
            OP_POP_LAST: begin
                r_ek <= q_k;
                r_ew <= q_w;
                r_i  <= '0;
            end
            OP_CMP_L: begin
                r_bidx <= l_idx[AW-1:0];
                if (above(is_max, q_k, q_w, r_ek, r_ew)) begin
                    r_bk    <= q_k;
                    r_bw    <= q_w;
                    r_moved <= 1'b1;
                end else begin
                    r_bk    <= r_ek;
                    r_bw    <= r_ew;
                    r_moved <= 1'b0;
                end
            end
            OP_CMP_R: begin
                if (r_in && above(is_max, q_k, q_w, r_bk, r_bw)) begin
                    r_bk    <= q_k;
                    r_bw    <= q_w;
                    r_bidx  <= r_idx[AW-1:0];
                    r_moved <= 1'b1;
                end
            end
            OP_WR_B:  r_i <= r_bidx;
            OP_WR_UP: r_i <= par;
            OP_TAKE:  r_take <= (rem < r_num) ? rem : r_num;
            OP_PUSH_LD: begin
                r_h  <= ph;
                r_ek <= pkey;
                r_ew <= pwt;
            end
            OP_SET_FULL:  r_full <= 1'b1;
            OP_PUSH_GROW: r_i <= size_h[AW-1:0];
            OP_DIST: r_dist <= ($signed(r_a) < $signed(r_pos)) ? r_pos - r_a : r_a - r_pos;
            OP_MUL_LO: r_prod <= mul_p;
            OP_MIN_HI: r_prod <= {mul_p[31:0], 32'd0};
            OP_MIN_END: r_used <= r_used + r_take;
            OP_EV_INIT: begin
                r_acc    <= r_min;
                r_h      <= 1'b0;
                r_eidx   <= '0;
                r_iseval <= 1'b1;
            end
            OP_EV_NEXT: begin
                r_h    <= 1'b1;
                r_eidx <= '0;
            end
            OP_EV_DIFF: begin
                r_take <= q_w;
                if (is_max) begin
                    r_hit  <= ($signed(r_a) < $signed(ev_pos));
                    r_dist <= ev_pos - r_a;
                end else begin
                    r_hit  <= ($signed(ev_pos) < $signed(r_a));
                    r_dist <= r_a - ev_pos;
                end
            end
            OP_EV_HI: begin
                if (r_hit) r_acc <= r_acc + r_prod;
                r_prod <= {mul_p[31:0], 32'd0};
            end
            OP_EV_END: begin
                if (r_hit) r_acc <= r_acc + r_prod;
                r_eidx <= r_eidx + SW'(1);
            end
            default: ;
        endcase
    end

    assign o_stat.func       = r_func;
    assign o_stat.loop_go    = (r_used < r_cnt) && (size_s != '0);
    assign o_stat.brk        = is_max ? !($signed(r_a) < $signed(top))
                                      : !($signed(top) < $signed(r_a));
    assign o_stat.pop_single = (size_h == SW'(1));
    assign o_stat.l_in       = (l_idx < n_ext);
    assign o_stat.moved      = r_moved;
    assign o_stat.p_zero     = (r_ew == '0);
    assign o_stat.p_full     = (size_h >= SW'(HEAP_DEPTH));
    assign o_stat.i_zero     = (r_i == '0);
    assign o_stat.up         = above(is_max, r_ek, r_ew, q_k, q_w);
    assign o_stat.ev_more    = (r_eidx < size_h);
    assign o_stat.ev_right   = r_h;

    assign o_min_value  = r_min;
    assign o_eval_value = r_iseval ? r_acc : r_min;
    assign o_status     = r_rev ? ST_REVERSED : (r_full ? ST_FULL : ST_OK);

endmodule

### rtl/convex_piecewise_linear_engine.sv
`timescale 1ns / 1ps

// Slope-trick engine: a convex piecewise-linear function held as a running
// minimum plus a left max-heap and a right min-heap of weighted breakpoints,
// each in a single-port-read memory of HEAP_DEPTH entries. Pulse start while
// busy is low; busy stays high until the single result, which appears for
// exactly one cycle with o_valid high and cannot be held off. Shift and
// cumulative min go straight from dispatch to the result. An add ends with a
// final push and, for every breakpoint moved, does one pop and three pushes;
// every sift step waits on the one registered read of the heap memory.
// Evaluate walks every stored breakpoint in both heaps serially, through the
// memories and the shared 32x32 multiplier.
module convex_piecewise_linear_engine import cple_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_pos_a,
    input  logic [31:0] i_pos_b,
    input  logic [31:0] i_slope_count,
    output logic        o_valid,
    output logic [63:0] o_min_value,
    output logic [63:0] o_eval_value,
    output logic [1:0]  o_status
);

    t_cmd  cmd;
    t_stat stat;

    cple_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cple_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_func        (i_func),
        .i_pos_a       (i_pos_a),
        .i_pos_b       (i_pos_b),
        .i_slope_count (i_slope_count),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_min_value   (o_min_value),
        .o_eval_value  (o_eval_value),
        .o_status      (o_status)
    );

endmodule
